@@ hdl/uad_pkg.sv @@
// shared types and constants of the usb accessory detect core
package uad_pkg;

    localparam int CfgAddrWidth = 3;
    localparam int CfgDataWidth = 32;
    localparam int DelayWidth   = 10;
    localparam int FirstWidth   = 8;

    localparam logic [CfgAddrWidth-3:0] RegFirstDelay  = 1'b0;
    localparam logic [CfgAddrWidth-3:0] RegSettleDelay = 1'b1;

    localparam logic [FirstWidth-1:0] FirstDelayReset  = 8'd11;
    localparam logic [DelayWidth-1:0] SettleDelayReset = 10'd100;

    typedef enum logic [2:0] {
        ST_CONFIG   = 3'd0,
        ST_SAMPLE   = 3'd1,
        ST_DEBOUNCE = 3'd2,
        ST_IDENTIFY = 3'd3,
        ST_USB      = 3'd4,
        ST_FACTORY  = 3'd5,
        ST_CHARGER  = 3'd6
    } ctl_state_t;

    typedef enum logic [1:0] {
        ACC_NONE    = 2'd0,
        ACC_USB     = 2'd1,
        ACC_FACTORY = 2'd2,
        ACC_CHARGER = 2'd3
    } acc_t;

    // port setups applied by the detection steps
    typedef enum logic [1:0] {
        PORT_NONE    = 2'd0,
        PORT_USB     = 2'd1,
        PORT_CHARGER = 2'd2,
        PORT_UNKNOWN = 2'd3
    } port_mode_t;

    // sense bits, id_float in bit 0
    typedef struct packed {
        logic single_ended_one;
        logic session_valid;
        logic vbus_valid;
        logic charge_current;
        logic id_ground;
        logic id_float;
    } sense_t;

    typedef struct packed {
        logic pulldowns_by_host;
        logic pullup_by_host;
        logic transceiver_enable;
        logic vbus_pulldown;
    } hw_ctl_t;

    typedef struct packed {
        logic id_float;
        logic id_ground;
        logic charge_current;
        logic vbus_valid;
        logic session_valid;
        logic single_ended_one;
    } in_beat_t;

    typedef struct packed {
        ctl_state_t            next_state;
        acc_t                  accessory;
        logic                  reschedule;
        logic [DelayWidth-1:0] delay_ms;
        logic                  supply_enable;
        logic                  vbus_pulldown;
        logic                  transceiver_enable;
        logic                  pullup_by_host;
        logic                  pulldowns_by_host;
        logic [4:0]            irq_enable;
    } out_beat_t;

    localparam logic [5:0] PatUsb      = 6'b011101;
    localparam logic [5:0] PatUsbFlash = 6'b011100;
    localparam logic [5:0] PatFactory  = 6'b011111;
    localparam logic [5:0] PatChgFloat = 6'b111101;
    localparam logic [5:0] PatCharger  = 6'b111100;

    localparam logic [4:0] IrqChrgDet = 5'b00001;
    localparam logic [4:0] IrqCurr    = 5'b00010;
    localparam logic [4:0] IrqSe1     = 5'b00100;
    localparam logic [4:0] IrqIdGnd   = 5'b01000;
    localparam logic [4:0] IrqVbus    = 5'b10000;

endpackage

@@ hdl/usb_accessory_detect_fsm_core.sv @@
// usb accessory detect state machine with input and result registers
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  in      | input     | in_valid/in_stall   | in_data (six sense bits)
//  out     | output    | out_valid/out_stall | out_data (state, controls)
//  cfg     | input     | apb, pready high   | first/settle delay regs
//
// a beat is held in the input register and then lands in the result register,
// one beat per cycle while no stall holds the result register; the state
// update for a beat happens in the same cycle it moves into the result register.
// reset puts the machine in configure with supply off, all irqs masked and
// delays at 11 and 100 ms.
// a stall on out holds the result register and backs up into in_stall once the
// input register is also full.
module usb_accessory_detect_fsm_core
    import uad_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  in_beat_t                in_data,

    output logic                    out_valid,
    input  logic                    out_stall,
    output out_beat_t               out_data,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CfgAddrWidth-1:0] paddr,
    input  logic [CfgDataWidth-1:0] pwdata,
    output logic [CfgDataWidth-1:0] prdata,
    output logic                    pready
);

    logic [FirstWidth-1:0] first_delay_reg;
    logic [DelayWidth-1:0] settle_delay_reg;

    logic       in_vld_reg;
    in_beat_t   in_beat_reg;
    logic       out_vld_reg;
    out_beat_t  out_beat_reg;

    ctl_state_t state_reg, state_next;
    logic [5:0] last_sense_reg, last_sense_next;
    acc_t       acc_reg, acc_next;
    logic [4:0] irq_reg, irq_next;
    logic       supply_reg, supply_next;
    hw_ctl_t    hw_reg, hw_next;

    logic                  resched;
    logic [DelayWidth-1:0] delay;
    sense_t                s;
    logic                  out_free;
    logic                  advance;
    logic                  cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_delay_reg  <= FirstDelayReset;
            settle_delay_reg <= SettleDelayReset;
        end
        else if (cfg_wr)
        begin
            if (paddr[CfgAddrWidth-1:2] == RegFirstDelay)
                first_delay_reg <= pwdata[FirstWidth-1:0];
            else
                settle_delay_reg <= pwdata[DelayWidth-1:0];
        end
    end

    always_comb
    begin
        if (paddr[CfgAddrWidth-1:2] == RegSettleDelay)
            prdata = {{(CfgDataWidth-DelayWidth){1'b0}}, settle_delay_reg};
        else
            prdata = {{(CfgDataWidth-FirstWidth){1'b0}}, first_delay_reg};
    end

    // handshake between the two register stages
    assign out_free  = ~out_vld_reg | ~out_stall;
    assign advance   = in_vld_reg & out_free;
    assign in_stall  = in_vld_reg & ~out_free;
    assign out_valid = out_vld_reg;
    assign out_data  = out_beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_vld_reg <= in_valid;
            if (out_free)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_beat_reg <= in_data;
    end

    function automatic hw_ctl_t set_port(hw_ctl_t hw, port_mode_t mode);
        hw_ctl_t h;
        h = hw;
        h.pullup_by_host = 1'b1;
        case (mode)
            PORT_USB:
            begin
                h.vbus_pulldown      = 1'b0;
                h.pullup_by_host     = 1'b0;
                h.pulldowns_by_host  = 1'b0;
                h.transceiver_enable = 1'b1;
            end
            PORT_CHARGER: h.vbus_pulldown = 1'b1;
            PORT_UNKNOWN: h.vbus_pulldown = 1'b0;
            default:
            begin
                h.vbus_pulldown      = 1'b1;
                h.transceiver_enable = 1'b0;
            end
        endcase
        return h;
    endfunction

    always_comb
    begin
        s.id_float         = in_beat_reg.id_float;
        s.id_ground        = in_beat_reg.id_ground;
        s.charge_current   = in_beat_reg.charge_current;
        s.vbus_valid       = in_beat_reg.vbus_valid;
        s.session_valid    = in_beat_reg.session_valid;
        s.single_ended_one = in_beat_reg.single_ended_one;

        state_next      = state_reg;
        last_sense_next = last_sense_reg;
        acc_next        = acc_reg;
        irq_next        = irq_reg;
        supply_next     = supply_reg;
        hw_next         = hw_reg;
        resched         = 1'b0;
        delay           = '0;

        case (state_reg)
            ST_CONFIG:
            begin
                supply_next = 1'b1;
                irq_next    = '0;
                hw_next     = set_port(hw_reg, PORT_UNKNOWN);
                state_next  = ST_SAMPLE;
                resched     = 1'b1;
                delay       = {{(DelayWidth-FirstWidth){1'b0}}, first_delay_reg};
            end
            ST_SAMPLE:
            begin
                last_sense_next = s;
                state_next      = ST_DEBOUNCE;
                resched         = 1'b1;
                delay           = settle_delay_reg;
            end
            ST_DEBOUNCE:
            begin
                last_sense_next = s;
                resched         = 1'b1;
                if (last_sense_reg != s)
                    delay = settle_delay_reg;
                else
                begin
                    state_next = ST_IDENTIFY;
                    // floating id with no session yet needs another settle wait
                    if (!s.single_ended_one && s.id_float && !s.id_ground && !s.session_valid)
                        delay = settle_delay_reg;
                end
            end
            ST_IDENTIFY:
            begin
                last_sense_next = s;
                if (s inside {PatUsb, PatUsbFlash})
                begin
                    hw_next    = set_port(hw_reg, PORT_USB);
                    acc_next   = ACC_USB;
                    irq_next   = irq_reg | IrqChrgDet | IrqCurr | IrqSe1 | IrqIdGnd;
                    state_next = ST_USB;
                end
                else if (s == PatFactory)
                begin
                    hw_next    = set_port(hw_reg, PORT_USB);
                    acc_next   = ACC_FACTORY;
                    irq_next   = irq_reg | IrqSe1;
                    state_next = ST_FACTORY;
                end
                else if (s inside {PatChgFloat, PatCharger})
                begin
                    hw_next    = set_port(hw_reg, PORT_CHARGER);
                    acc_next   = ACC_CHARGER;
                    irq_next   = irq_reg | IrqCurr | IrqSe1 | IrqIdGnd;
                    state_next = ST_CHARGER;
                end
                else
                begin
                    hw_next     = set_port(hw_reg, PORT_NONE);
                    acc_next    = ACC_NONE;
                    supply_next = 1'b0;
                    irq_next    = irq_reg | IrqChrgDet | IrqCurr | IrqVbus;
                    state_next  = ST_CONFIG;
                end
            end
            ST_USB:
            begin
                last_sense_next = s;
                if (s.single_ended_one || s.id_ground || !s.vbus_valid)
                begin
                    if (s.single_ended_one)
                    begin
                        hw_next.pullup_by_host    = 1'b1;
                        hw_next.pulldowns_by_host = 1'b1;
                    end
                    state_next = ST_CONFIG;
                    resched    = 1'b1;
                end
                else
                    irq_next = irq_reg | IrqChrgDet | IrqCurr | IrqSe1 | IrqIdGnd;
            end
            ST_FACTORY:
            begin
                last_sense_next = s;
                if (s.single_ended_one)
                begin
                    state_next = ST_CONFIG;
                    resched    = 1'b1;
                end
                else
                    irq_next = irq_reg | IrqSe1;
            end
            ST_CHARGER:
            begin
                last_sense_next = s;
                if (!s.single_ended_one || (!s.vbus_valid && !s.charge_current))
                begin
                    state_next = ST_CONFIG;
                    resched    = 1'b1;
                end
                else
                    irq_next = irq_reg | IrqCurr | IrqSe1 | IrqIdGnd;
            end
            default:
            begin
                // unused code: drop the supply and restart at once
                supply_next = 1'b0;
                state_next  = ST_CONFIG;
                resched     = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CONFIG;
            last_sense_reg <= '0;
            acc_reg        <= ACC_NONE;
            irq_reg        <= '0;
            supply_reg     <= 1'b0;
            hw_reg         <= '0;
        end
        else if (advance)
        begin
            state_reg      <= state_next;
            last_sense_reg <= last_sense_next;
            acc_reg        <= acc_next;
            irq_reg        <= irq_next;
            supply_reg     <= supply_next;
            hw_reg         <= hw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_beat_reg.next_state         <= state_next;
            out_beat_reg.accessory          <= acc_next;
            out_beat_reg.reschedule         <= resched;
            out_beat_reg.delay_ms           <= delay;
            out_beat_reg.supply_enable      <= supply_next;
            out_beat_reg.vbus_pulldown      <= hw_next.vbus_pulldown;
            out_beat_reg.transceiver_enable <= hw_next.transceiver_enable;
            out_beat_reg.pullup_by_host     <= hw_next.pullup_by_host;
            out_beat_reg.pulldowns_by_host  <= hw_next.pulldowns_by_host;
            out_beat_reg.irq_enable         <= irq_next;
        end
    end

`ifndef SYNTHESIS
    a_delay_needs_resched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.reschedule |-> out_data.delay_ms == '0)
        else $error("delay given without a reschedule request");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the result register can take a beat");

    a_usb_state_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.next_state == ST_USB |-> out_data.accessory == ACC_USB)
        else $error("usb watch state without a usb accessory");

    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !out_stall |=> out_valid)
        else $error("beat from the input register did not reach the result register");
`endif

endmodule
